// ===== sv/tsse_pkg.sv =====
// Shared types, constants and helpers for the task scheduler and semaphore engine.
// No dependencies; every other file imports this package.
package tsse_pkg;

  localparam int TASK_SLOTS  = 16;
  localparam int TASK_W      = 4;
  localparam int TOTAL_W     = 5;
  localparam int SEM_COUNT   = 8;
  localparam int SEM_W       = 3;
  localparam int QUEUE_DEPTH = 8;
  localparam int QPOS_W      = 3;
  localparam int QLEN_W      = 4;
  localparam int QADDR_W     = SEM_W + QPOS_W;
  localparam int PRIO_LEVELS = 8;
  localparam int PRIO_W      = 3;
  localparam int LVL_W       = 3;
  localparam int CNT_W       = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ST_INVALID = 3'd0,
    ST_UNRUN   = 3'd1,
    ST_READY   = 3'd2,
    ST_DELAYED = 3'd3,
    ST_BLOCKED = 3'd4,
    ST_KILLED  = 3'd5
  } task_state_t;

  typedef enum logic [3:0] {
    K_TICK    = 4'd0,
    K_YIELD   = 4'd1,
    K_SLEEP   = 4'd2,
    K_WAIT    = 4'd3,
    K_POST    = 4'd4,
    K_PICK    = 4'd5,
    K_CREATE  = 4'd6,
    K_KILL    = 4'd7,
    K_RESTART = 4'd8,
    K_SET_SEM = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    STS_OK         = 3'd0,
    STS_BLOCKED    = 3'd1,
    STS_QUEUE_FULL = 3'd2,
    STS_NO_SLOT    = 3'd3,
    STS_NOT_FOUND  = 3'd4,
    STS_NONE_READY = 3'd5,
    STS_BAD_INDEX  = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_TICK, S_POST_HEAD, S_SHIFT_RD, S_SHIFT_WR,
    S_KILL_RD, S_KILL_CMP, S_PICK_PRIO, S_PICK_RR, S_PICK_FIN, S_ORDER, S_DONE
  } seq_state_t;

  localparam logic [0:0] REG_PRIORITY_MODE  = 1'b0;
  localparam logic [0:0] REG_PREEMPT_ENABLE = 1'b1;

  // Wait queue memory request
  typedef struct packed {
    logic               wr_en;
    logic [QADDR_W-1:0] wr_addr;
    logic [TASK_W-1:0]  wr_data;
    logic               rd_en;
    logic [QADDR_W-1:0] rd_addr;
  } qmem_req_t;

  function automatic logic runnable(task_state_t s);
    return (s == ST_UNRUN) || (s == ST_READY);
  endfunction

endpackage

// ===== sv/tsse_queue.sv =====
// Semaphore wait queue store: one write and one registered read port.
// Depends on tsse_pkg.
module tsse_queue (
  input  logic                      clk,
  input  tsse_pkg::qmem_req_t       req,
  output logic [tsse_pkg::TASK_W-1:0] rd_data
);
  import tsse_pkg::*;

  logic [TASK_W-1:0] mem [SEM_COUNT*QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== sv/task_scheduler_semaphore_engine.sv =====
// Top level: task scheduler with counting semaphores, sequenced one event at a time.
// Depends on tsse_pkg and tsse_queue.
//
// Channel  Direction  Handshake              Content
// in_      slave      tvalid/tready          one kernel event per item
// out_     master     tvalid/tready          one result per event
// cfg_     APB slave  psel/penable/pready    priority_mode (0x0), preempt_enable (0x4)
//
// Per item: tick walks the 16 slots one per cycle, pick scans up to 16 slots, create
// rebuilds the priority order over 8 levels x tasks, and queue removal moves one entry
// at a time through the wait queue memory port, reading each entry and writing it back.
// Reset is synchronous and active low; no clearing pass is needed.
// in_tready is high only while idle; a result held by a stalled out_ channel stalls
// completion of the next item only.
module task_scheduler_semaphore_engine (
  input  logic        clk,
  input  logic        rst_n,
  // in_tuser: kind[3:0]
  // in_tdata: task_index[3:0], sem_index[6:4], sleep_ticks[38:7], new_priority[41:39],
  //           initial_count[49:42], zero[55:50]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,
  input  logic [3:0]  in_tuser,
  // out_tdata: chosen_task[3:0], status[6:4], switch_request[7], first_run[8],
  //            woken_mask[24:9], zero[31:25]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tsse_pkg::*;

  seq_state_t  state_r, state_nxt;
  task_state_t st_r [TASK_SLOTS];
  task_state_t st_nxt [TASK_SLOTS];
  logic [31:0]       tick_r [TASK_SLOTS];
  logic [31:0]       tick_nxt [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_r [TASK_SLOTS];
  logic [PRIO_W-1:0] prio_nxt [TASK_SLOTS];
  logic [SEM_W-1:0]  wsem_r [TASK_SLOTS];
  logic [SEM_W-1:0]  wsem_nxt [TASK_SLOTS];
  logic [TASK_W-1:0] order_r [TASK_SLOTS];
  logic [TASK_W-1:0] order_nxt [TASK_SLOTS];
  logic [CNT_W-1:0]  cnt_r [SEM_COUNT];
  logic [CNT_W-1:0]  cnt_nxt [SEM_COUNT];
  logic [QLEN_W-1:0] qlen_r [SEM_COUNT];
  logic [QLEN_W-1:0] qlen_nxt [SEM_COUNT];
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic [TASK_W-1:0]  cur_r, cur_nxt, rr_r, rr_nxt, ppos_r, ppos_nxt;
  logic mode_r, mode_nxt, pre_r, pre_nxt;
  logic out_valid_r, out_valid_nxt;

  // latched item and working registers
  logic [3:0]         kind_r, kind_nxt;
  logic [TASK_W-1:0]  tix_r, tix_nxt;
  logic [SEM_W-1:0]   six_r, six_nxt, qs_r, qs_nxt;
  logic [31:0]        sticks_r, sticks_nxt;
  logic [PRIO_W-1:0]  nprio_r, nprio_nxt;
  logic [CNT_W-1:0]   icnt_r, icnt_nxt;
  logic [TOTAL_W-1:0] idx_r, idx_nxt, pos_r, pos_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [TASK_W-1:0]  res_chosen_r, res_chosen_nxt;
  logic [2:0]         res_status_r, res_status_nxt;
  logic               res_sw_r, res_sw_nxt, res_first_r, res_first_nxt;
  logic [15:0]        res_woken_r, res_woken_nxt;
  logic [31:0]        out_data_r, out_data_nxt;

  qmem_req_t         qreq;
  logic [TASK_W-1:0] q_rdata;

  tsse_queue u_queue (
    .clk     (clk),
    .req     (qreq),
    .rd_data (q_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_PREEMPT_ENABLE) ? {31'd0, pre_r} : {31'd0, mode_r};

  // sequencer: next state, state updates and queue requests
  always_comb begin
    logic [TASK_W-1:0]  t;
    logic [TOTAL_W-1:0] p;
    logic [QLEN_W-1:0]  pn;
    state_nxt = state_r;
    st_nxt = st_r; tick_nxt = tick_r; prio_nxt = prio_r; wsem_nxt = wsem_r;
    order_nxt = order_r; cnt_nxt = cnt_r; qlen_nxt = qlen_r;
    total_nxt = total_r; cur_nxt = cur_r; rr_nxt = rr_r; ppos_nxt = ppos_r;
    mode_nxt = mode_r; pre_nxt = pre_r;
    kind_nxt = kind_r; tix_nxt = tix_r; six_nxt = six_r; qs_nxt = qs_r;
    sticks_nxt = sticks_r; nprio_nxt = nprio_r; icnt_nxt = icnt_r;
    idx_nxt = idx_r; pos_nxt = pos_r; lvl_nxt = lvl_r;
    res_chosen_nxt = res_chosen_r; res_status_nxt = res_status_r;
    res_sw_nxt = res_sw_r; res_first_nxt = res_first_r; res_woken_nxt = res_woken_r;
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    qreq = '0;
    t = '0; p = '0; pn = '0;

    // configuration writes
    if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_PREEMPT_ENABLE) pre_nxt = cfg_pwdata[0];
      else mode_nxt = cfg_pwdata[0];
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt   = in_tuser;
          tix_nxt    = in_tdata[3:0];
          six_nxt    = in_tdata[6:4];
          sticks_nxt = in_tdata[38:7];
          nprio_nxt  = in_tdata[41:39];
          icnt_nxt   = in_tdata[49:42];
          res_chosen_nxt = '0; res_status_nxt = STS_OK; res_sw_nxt = 1'b0;
          res_first_nxt = 1'b0; res_woken_nxt = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (kind_r)
          K_TICK: begin
            idx_nxt = '0;
            res_sw_nxt = pre_r;
            state_nxt = S_TICK;
          end
          K_YIELD: res_sw_nxt = 1'b1;
          K_SLEEP: begin
            if (st_r[cur_r] != ST_READY) begin
              res_status_nxt = STS_BAD_INDEX;
            end else begin
              tick_nxt[cur_r] = sticks_r;
              st_nxt[cur_r] = ST_DELAYED;
              res_sw_nxt = 1'b1;
            end
          end
          K_WAIT: begin
            if (st_r[cur_r] != ST_READY) begin
              res_status_nxt = STS_BAD_INDEX;
            end else if (cnt_r[six_r] != '0) begin
              cnt_nxt[six_r] = cnt_r[six_r] - 1'b1;
            end else if (qlen_r[six_r] < QLEN_W'(QUEUE_DEPTH)) begin
              qreq.wr_en   = 1'b1;
              qreq.wr_addr = {six_r, qlen_r[six_r][QPOS_W-1:0]};
              qreq.wr_data = cur_r;
              qlen_nxt[six_r] = qlen_r[six_r] + 1'b1;
              wsem_nxt[cur_r] = six_r;
              st_nxt[cur_r] = ST_BLOCKED;
              res_status_nxt = STS_BLOCKED;
              res_sw_nxt = 1'b1;
            end else begin
              res_status_nxt = STS_QUEUE_FULL;
            end
          end
          K_POST: begin
            if (qlen_r[six_r] != '0) begin
              qreq.rd_en   = 1'b1;
              qreq.rd_addr = {six_r, QPOS_W'(0)};
              qs_nxt = six_r;
              state_nxt = S_POST_HEAD;
            end else if (cnt_r[six_r] != CNT_MAX) begin
              cnt_nxt[six_r] = cnt_r[six_r] + 1'b1;
            end
          end
          K_PICK: begin
            idx_nxt = '0;
            pos_nxt = {1'b0, ppos_r};
            state_nxt = mode_r ? S_PICK_PRIO : S_PICK_RR;
          end
          K_CREATE: begin
            // slots fill in order and never return to invalid
            if (total_r >= TOTAL_W'(TASK_SLOTS)) begin
              res_status_nxt = STS_NO_SLOT;
            end else begin
              t = total_r[TASK_W-1:0];
              st_nxt[t]   = ST_UNRUN;
              tick_nxt[t] = '0;
              prio_nxt[t] = (nprio_r > PRIO_W'(PRIO_LEVELS-1)) ? PRIO_W'(PRIO_LEVELS-1) : nprio_r;
              wsem_nxt[t] = '0;
              total_nxt = total_r + 1'b1;
              res_chosen_nxt = t;
              idx_nxt = '0; pos_nxt = '0; lvl_nxt = '0;
              state_nxt = S_ORDER;
            end
          end
          K_KILL: begin
            if (st_r[tix_r] == ST_INVALID) begin
              res_status_nxt = STS_NOT_FOUND;
            end else begin
              st_nxt[tix_r] = ST_KILLED;
              if (st_r[tix_r] == ST_BLOCKED) begin
                qs_nxt = wsem_r[tix_r];
                idx_nxt = '0;
                state_nxt = S_KILL_RD;
              end
            end
          end
          K_RESTART: begin
            if (st_r[tix_r] != ST_KILLED) res_status_nxt = STS_NOT_FOUND;
            else st_nxt[tix_r] = ST_UNRUN;
          end
          K_SET_SEM: cnt_nxt[six_r] = icnt_r;
          default: ;
        endcase
      end
      // one slot per cycle through the shared decrementer
      S_TICK: begin
        t = idx_r[TASK_W-1:0];
        if (st_r[t] == ST_DELAYED) begin
          if (tick_r[t] == '0) begin
            st_nxt[t] = ST_READY;
            res_woken_nxt = res_woken_r | (16'd1 << t);
          end else begin
            tick_nxt[t] = tick_r[t] - 1'b1;
          end
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == TOTAL_W'(TASK_SLOTS-1)) state_nxt = S_DONE;
      end
      S_POST_HEAD: begin
        st_nxt[q_rdata] = ST_READY;
        res_woken_nxt = res_woken_r | (16'd1 << q_rdata);
        pos_nxt = '0;
        state_nxt = S_SHIFT_RD;
      end
      // close the gap at pos: read pos+1, write it back at pos
      S_SHIFT_RD: begin
        pn = pos_r[QLEN_W-1:0] + 1'b1;
        if (pn < qlen_r[qs_r]) begin
          qreq.rd_en   = 1'b1;
          qreq.rd_addr = {qs_r, pn[QPOS_W-1:0]};
          state_nxt = S_SHIFT_WR;
        end else begin
          qlen_nxt[qs_r] = qlen_r[qs_r] - 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_SHIFT_WR: begin
        qreq.wr_en   = 1'b1;
        qreq.wr_addr = {qs_r, pos_r[QPOS_W-1:0]};
        qreq.wr_data = q_rdata;
        pos_nxt = pos_r + 1'b1;
        state_nxt = S_SHIFT_RD;
      end
      // search the queue for the killed task
      S_KILL_RD: begin
        if (idx_r < TOTAL_W'(qlen_r[qs_r])) begin
          qreq.rd_en   = 1'b1;
          qreq.rd_addr = {qs_r, idx_r[QPOS_W-1:0]};
          state_nxt = S_KILL_CMP;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_KILL_CMP: begin
        if (q_rdata == tix_r) begin
          pos_nxt = idx_r;
          state_nxt = S_SHIFT_RD;
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_KILL_RD;
        end
      end
      S_PICK_PRIO: begin
        if (idx_r == total_r) begin
          res_status_nxt = STS_NONE_READY;
          state_nxt = S_DONE;
        end else begin
          p = (pos_r >= total_r) ? '0 : pos_r;
          t = order_r[p[TASK_W-1:0]];
          pos_nxt = p + 1'b1;
          idx_nxt = idx_r + 1'b1;
          if (runnable(st_r[t])) begin
            ppos_nxt = TASK_W'(p + 1'b1);
            res_chosen_nxt = t;
            state_nxt = S_PICK_FIN;
          end
        end
      end
      S_PICK_RR: begin
        if (idx_r == TOTAL_W'(TASK_SLOTS)) begin
          res_status_nxt = STS_NONE_READY;
          state_nxt = S_DONE;
        end else begin
          t = rr_r + 1'b1 + idx_r[TASK_W-1:0];
          idx_nxt = idx_r + 1'b1;
          if (runnable(st_r[t])) begin
            rr_nxt = t;
            res_chosen_nxt = t;
            state_nxt = S_PICK_FIN;
          end
        end
      end
      S_PICK_FIN: begin
        cur_nxt = res_chosen_r;
        if (st_r[res_chosen_r] == ST_UNRUN) begin
          st_nxt[res_chosen_r] = ST_READY;
          res_first_nxt = 1'b1;
          res_woken_nxt = 16'd1 << res_chosen_r;
        end
        state_nxt = S_DONE;
      end
      // priority order rebuild: one task per cycle, one level per pass
      S_ORDER: begin
        if (idx_r < total_r) begin
          if (prio_r[idx_r[TASK_W-1:0]] == lvl_r) begin
            order_nxt[pos_r[TASK_W-1:0]] = idx_r[TASK_W-1:0];
            pos_nxt = pos_r + 1'b1;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          idx_nxt = '0;
          lvl_nxt = lvl_r + 1'b1;
          if (lvl_r == LVL_W'(PRIO_LEVELS-1)) begin
            ppos_nxt = '0;
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt = {7'd0, res_woken_r, res_first_r, res_sw_r, res_status_r, res_chosen_r};
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < TASK_SLOTS; i++) st_r[i] <= ST_INVALID;
      for (int i = 0; i < SEM_COUNT; i++) begin
        cnt_r[i]  <= '0;
        qlen_r[i] <= '0;
      end
      total_r <= '0;
      cur_r <= '0;
      rr_r <= TASK_W'(TASK_SLOTS-1);
      ppos_r <= '0;
      mode_r <= 1'b1;
      pre_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      qlen_r <= qlen_nxt;
      total_r <= total_nxt;
      cur_r <= cur_nxt;
      rr_r <= rr_nxt;
      ppos_r <= ppos_nxt;
      mode_r <= mode_nxt;
      pre_r <= pre_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    tick_r <= tick_nxt; prio_r <= prio_nxt; wsem_r <= wsem_nxt; order_r <= order_nxt;
    kind_r <= kind_nxt; tix_r <= tix_nxt; six_r <= six_nxt; qs_r <= qs_nxt;
    sticks_r <= sticks_nxt; nprio_r <= nprio_nxt; icnt_r <= icnt_nxt;
    idx_r <= idx_nxt; pos_r <= pos_nxt; lvl_r <= lvl_nxt;
    res_chosen_r <= res_chosen_nxt; res_status_r <= res_status_nxt;
    res_sw_r <= res_sw_nxt; res_first_r <= res_first_nxt; res_woken_r <= res_woken_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
